// ===== rtl/core/gee_pkg.sv =====
// package with payload word types and fixed constants of the eccentricity engine
`timescale 1ns / 1ps
`default_nettype none
package gee_pkg;

  localparam int DIST_BITS = 12;
  localparam logic [DIST_BITS-1:0] DIST_MAX = 12'd4095;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_RUN   = 1'b1;

  typedef struct packed {
    logic       op;
    logic [3:0] row_vertex;
    logic [3:0] col_vertex;
    logic [7:0] edge_weight;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  vertex_index;
    logic [11:0] eccentricity;
    logic        is_central;
    logic        is_peripheral;
    logic        is_isolated;
    logic        is_dominating;
    logic        is_leaf;
    logic [11:0] radius;
    logic        radius_found;
    logic [11:0] diameter;
    logic        last_result;
  } out_word_t;

endpackage
`default_nettype wire

// ===== rtl/core/gee_ram.sv =====
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module gee_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/graph_eccentricity_engine_core.sv =====
// top level of the graph eccentricity engine: matrix load, relaxation walk and result stream
// After reset the weight matrix is swept to zero, one entry a cycle; no word is
// taken meanwhile. A matrix write word is taken while the block is idle. A run
// word keeps the block busy: every source seeds its walk in S_SRC, then each
// vertex popped from the pending set passes S_PICK and S_DV, then S_RD and S_WR
// for each active column and a last S_RD, and S_PICK at last finds the set
// empty, all through the one weight port and one distance port; then S_EREAD and
// S_EACC form the eccentricity. A summary pass in S_SUM_RD and S_SUM_ACC finds
// radius and diameter, and each result word waits for its degree count in
// S_DEG_RD and S_DEG_ACC before it is shown and held until taken. The vertex count
// register is written with cfg_we.
`timescale 1ns / 1ps
`default_nettype none
module graph_eccentricity_engine_core #(
  parameter int MAX_VERTICES = 16,
  parameter int WEIGHT_BITS  = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire gee_pkg::in_word_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output gee_pkg::out_word_t     out_data,
  input  wire logic              cfg_we,
  input  wire logic [4:0]        cfg_data
);

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int AW = 2 * VW;
  localparam int SW = ((WEIGHT_BITS > gee_pkg::DIST_BITS) ? WEIGHT_BITS
                       : gee_pkg::DIST_BITS) + 1;
  localparam int DB = gee_pkg::DIST_BITS;

  typedef enum logic [14:0] {
    S_CLEAR   = 15'b000000000000001,
    S_IDLE    = 15'b000000000000010,
    S_SRC     = 15'b000000000000100,
    S_PICK    = 15'b000000000001000,
    S_DV      = 15'b000000000010000,
    S_RD      = 15'b000000000100000,
    S_WR      = 15'b000000001000000,
    S_EREAD   = 15'b000000010000000,
    S_EACC    = 15'b000000100000000,
    S_SUM_RD  = 15'b000001000000000,
    S_SUM_ACC = 15'b000010000000000,
    S_OUT_RD  = 15'b000100000000000,
    S_OUT_E   = 15'b001000000000000,
    S_DEG_RD  = 15'b010000000000000,
    S_DEG_ACC = 15'b100000000000000
  } state_t;

  state_t state;
  logic emit;

  logic [4:0]              vertex_count;
  logic [CW-1:0]           cnt;
  logic [AW-1:0]           clr;
  logic [CW-1:0]           src;
  logic [CW-1:0]           idx;
  logic [VW-1:0]           cur;
  logic [VW-1:0]           pick;
  logic [MAX_VERTICES-1:0] reached;
  logic [MAX_VERTICES-1:0] pending;
  logic [DB-1:0]           dv;
  logic [DB-1:0]           acc;
  logic [DB-1:0]           rad;
  logic [DB-1:0]           dia;
  logic                    found;
  logic [DB-1:0]           ecc_val;
  logic [CW-1:0]           deg;

  logic                   wt_we;
  logic [AW-1:0]          wt_waddr;
  logic [WEIGHT_BITS-1:0] wt_wdata;
  logic [AW-1:0]          wt_raddr;
  logic [WEIGHT_BITS-1:0] wt_rdata;
  logic                   ds_we;
  logic [VW-1:0]          ds_waddr;
  logic [DB-1:0]          ds_wdata;
  logic [VW-1:0]          ds_raddr;
  logic [DB-1:0]          ds_rdata;
  logic                   ec_we;
  logic [VW-1:0]          ec_raddr;
  logic [DB-1:0]          ec_rdata;

  logic [SW-1:0] sum;
  logic [DB-1:0] nd;
  logic          relax;
  logic          in_acc;
  logic          row_ok;

  assign cnt = (int'(vertex_count) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(vertex_count);
  assign in_stall = (state != S_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign row_ok = (int'(in_data.row_vertex) < MAX_VERTICES) &&
                  (int'(in_data.col_vertex) < MAX_VERTICES);

  // lowest pending vertex
  always_comb begin
    pick = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (pending[i]) begin
        pick = VW'(i);
      end
    end
  end

  assign sum = SW'(dv) + SW'(wt_rdata);
  assign nd = (sum > SW'(gee_pkg::DIST_MAX)) ? gee_pkg::DIST_MAX : sum[DB-1:0];
  assign relax = (wt_rdata != '0) &&
                 (!reached[idx[VW-1:0]] || (nd < ds_rdata));

  always_comb begin
    wt_we = 1'b0;
    wt_waddr = clr;
    wt_wdata = '0;
    if (state == S_CLEAR) begin
      wt_we = 1'b1;
    end else if (in_acc && in_data.op == gee_pkg::OP_WRITE && row_ok) begin
      wt_we = 1'b1;
      wt_waddr = {VW'(in_data.row_vertex), VW'(in_data.col_vertex)};
      wt_wdata = WEIGHT_BITS'(in_data.edge_weight);
    end
  end

  always_comb begin
    if (state == S_DEG_RD) begin
      wt_raddr = {src[VW-1:0], idx[VW-1:0]};
    end else begin
      wt_raddr = {cur, idx[VW-1:0]};
    end
  end

  always_comb begin
    ds_we = 1'b0;
    ds_waddr = idx[VW-1:0];
    ds_wdata = nd;
    if (state == S_SRC) begin
      ds_we = 1'b1;
      ds_waddr = src[VW-1:0];
      ds_wdata = '0;
    end else if (state == S_WR && relax) begin
      ds_we = 1'b1;
    end
  end

  assign ds_raddr = (state == S_PICK) ? pick : idx[VW-1:0];
  assign ec_we = (state == S_EREAD) && (idx == cnt);
  assign ec_raddr = (state == S_OUT_RD) ? src[VW-1:0] : idx[VW-1:0];

  gee_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(2 ** AW)) u_weight (
    .clk(clk), .we(wt_we), .waddr(wt_waddr), .wdata(wt_wdata),
    .raddr(wt_raddr), .rdata(wt_rdata)
  );

  gee_ram #(.WIDTH(DB), .DEPTH(2 ** VW)) u_dist (
    .clk(clk), .we(ds_we), .waddr(ds_waddr), .wdata(ds_wdata),
    .raddr(ds_raddr), .rdata(ds_rdata)
  );

  gee_ram #(.WIDTH(DB), .DEPTH(2 ** VW)) u_ecc (
    .clk(clk), .we(ec_we), .waddr(src[VW-1:0]), .wdata(acc),
    .raddr(ec_raddr), .rdata(ec_rdata)
  );

  assign emit = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      out_valid <= 1'b0;
      vertex_count <= 5'd16;
    end else begin
      if (cfg_we) begin
        vertex_count <= cfg_data;
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == {AW{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc && in_data.op == gee_pkg::OP_RUN && cnt != '0) begin
            src <= '0;
            found <= 1'b0;
            rad <= '0;
            dia <= '0;
            state <= S_SRC;
          end
        end
        S_SRC: begin
          reached <= MAX_VERTICES'(1) << src[VW-1:0];
          pending <= MAX_VERTICES'(1) << src[VW-1:0];
          acc <= '0;
          state <= S_PICK;
        end
        S_PICK: begin
          if (pending == '0) begin
            idx <= '0;
            state <= S_EREAD;
          end else begin
            cur <= pick;
            pending[pick] <= 1'b0;
            state <= S_DV;
          end
        end
        S_DV: begin
          dv <= ds_rdata;
          idx <= '0;
          state <= S_RD;
        end
        S_RD: begin
          state <= (idx == cnt) ? S_PICK : S_WR;
        end
        S_WR: begin
          if (relax) begin
            reached[idx[VW-1:0]] <= 1'b1;
            pending[idx[VW-1:0]] <= 1'b1;
          end
          idx <= idx + 1'b1;
          state <= S_RD;
        end
        S_EREAD: begin
          if (idx == cnt) begin
            idx <= '0;
            src <= src + 1'b1;
            state <= (src + 1'b1 == cnt) ? S_SUM_RD : S_SRC;
          end else begin
            state <= S_EACC;
          end
        end
        S_EACC: begin
          if (reached[idx[VW-1:0]] && ds_rdata > acc) begin
            acc <= ds_rdata;
          end
          idx <= idx + 1'b1;
          state <= S_EREAD;
        end
        S_SUM_RD: begin
          if (idx == cnt) begin
            src <= '0;
            state <= S_OUT_RD;
          end else begin
            state <= S_SUM_ACC;
          end
        end
        S_SUM_ACC: begin
          if (ec_rdata != '0) begin
            if (ec_rdata > dia) begin
              dia <= ec_rdata;
            end
            if (!found || ec_rdata < rad) begin
              rad <= ec_rdata;
              found <= 1'b1;
            end
          end
          idx <= idx + 1'b1;
          state <= S_SUM_RD;
        end
        S_OUT_RD: begin
          if (emit) begin
            if (!out_stall) begin
              out_valid <= 1'b0;
              if (src + 1'b1 == cnt) begin
                state <= S_IDLE;
              end else begin
                src <= src + 1'b1;
              end
            end
          end else begin
            idx <= '0;
            deg <= '0;
            state <= S_OUT_E;
          end
        end
        S_OUT_E: begin
          ecc_val <= ec_rdata;
          state <= S_DEG_RD;
        end
        S_DEG_RD: begin
          if (idx == cnt) begin
            out_data.vertex_index <= 4'(src);
            out_data.eccentricity <= ecc_val;
            out_data.is_central <= found && (ecc_val == rad);
            out_data.is_peripheral <= (ecc_val == dia);
            out_data.is_isolated <= (deg == '0);
            out_data.is_dominating <= ((CW+1)'(deg) + 1'b1 == (CW+1)'(cnt));
            out_data.is_leaf <= (deg == CW'(1));
            out_data.radius <= rad;
            out_data.radius_found <= found;
            out_data.diameter <= dia;
            out_data.last_result <= (src + 1'b1 == cnt);
            out_valid <= 1'b1;
            state <= S_OUT_RD;
          end else begin
            state <= S_DEG_ACC;
          end
        end
        S_DEG_ACC: begin
          if (wt_rdata != '0) begin
            deg <= deg + 1'b1;
          end
          idx <= idx + 1'b1;
          state <= S_DEG_RD;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_word_only_when_emitting: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OUT_RD)
    else $error("result word outside emit state");

  a_no_intake_during_run: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a result waits");

  a_pending_subset_reached: assert property (@(posedge clk) disable iff (rst)
    (state == S_PICK || state == S_RD || state == S_WR) |-> (pending & ~reached) == '0)
    else $error("pending vertex not reached");

  a_index_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD || state == S_EREAD || state == S_DEG_RD) |-> idx <= cnt)
    else $error("column index past vertex count");

endmodule
`default_nettype wire
